>>> rtl/lpwc_pkg.sv
// lpwc_pkg: shared codes and constants for the link low-power wake controller
// no dependencies; used by the interfaces and every rtl module of the block
package lpwc_pkg;

    // event opcodes
    localparam logic [2:0] OP_DISABLE     = 3'd0;
    localparam logic [2:0] OP_ENABLE      = 3'd1;
    localparam logic [2:0] OP_WAKE_ASSERT = 3'd2;
    localparam logic [2:0] OP_ALLOW_SLEEP = 3'd3;
    localparam logic [2:0] OP_TX_DONE     = 3'd4;
    localparam logic [2:0] OP_MODE_DONE   = 3'd5;
    localparam logic [2:0] OP_TICK        = 3'd6;

    // low-power mode states
    localparam logic [1:0] MODE_DISABLED  = 2'd0;
    localparam logic [1:0] MODE_ENABLED   = 2'd1;
    localparam logic [1:0] MODE_ENABLING  = 2'd2;
    localparam logic [1:0] MODE_DISABLING = 2'd3;

    // wake line states
    localparam logic [1:0] WAKE_DEASSERTED = 2'd0;
    localparam logic [1:0] WAKE_WAIT_TX    = 2'd1;
    localparam logic [1:0] WAKE_WAIT_IDLE  = 2'd2;
    localparam logic [1:0] WAKE_ASSERTED   = 2'd3;

    // mode requests
    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_ENABLE  = 2'd1;
    localparam logic [1:0] REQ_DISABLE = 2'd2;

    // wake commands
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_ASSERT   = 2'd1;
    localparam logic [1:0] CMD_DEASSERT = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BUSY    = 2'd1;
    localparam logic [1:0] STAT_ALREADY = 2'd2;
    localparam logic [1:0] STAT_UNKNOWN = 2'd3;

    // field widths
    localparam int OPCODE_BITS  = 3;
    localparam int TIMEOUT_BITS = 16;
    localparam int COUNT_BITS_DEFAULT = 16;

    // register port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_IDX_IDLE_TIMEOUT = 1'b0;

endpackage

>>> rtl/lpwc_if.sv
// lpwc event and result channels: valid/ready handshake plus payload
// depends on lpwc_pkg for field widths
interface lpwc_evt_if
    import lpwc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OPCODE_BITS-1:0] opcode;
    logic                   success;

    modport source (output valid, output opcode, output success, input ready);
    modport sink   (input valid, input opcode, input success, output ready);
endinterface

interface lpwc_res_if
    import lpwc_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] mode_request;
    logic [1:0] wake_command;
    logic [1:0] status;
    logic [1:0] mode_now;
    logic [1:0] wake_now;
    logic       timer_running;

    modport source (output valid, output mode_request, output wake_command, output status,
                    output mode_now, output wake_now, output timer_running, input ready);
    modport sink   (input valid, input mode_request, input wake_command, input status,
                    input mode_now, input wake_now, input timer_running, output ready);
endinterface

>>> rtl/link_low_power_wake_controller.sv
// link_low_power_wake_controller: low-power mode and wake line control for a radio link
// result: a result beat is valid in the cycle after its event beat is accepted
// throughput: one event per cycle, set by the single result register, while results are
//   taken; evt ready stays high while a held result is being taken in the same cycle
// reset: mode disabled, wake deasserted, tx finished set, countdown stopped, idle_timeout 0
// depends on lpwc_pkg, lpwc_if, lpwc_cfg and lpwc_core
module link_low_power_wake_controller
    import lpwc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    lpwc_evt_if.sink                 evt,
    lpwc_res_if.source               res
);

    logic [TIMEOUT_BITS-1:0] idle_timeout;

    lpwc_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .idle_timeout (idle_timeout)
    );

    lpwc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .idle_timeout (idle_timeout),
        .evt          (evt),
        .res          (res)
    );

endmodule

>>> rtl/lpwc_cfg.sv
// lpwc_cfg: apb register file holding the idle timeout
// depends on lpwc_pkg
module lpwc_cfg
    import lpwc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output logic [TIMEOUT_BITS-1:0]  idle_timeout
);

    logic [TIMEOUT_BITS-1:0] idle_timeout_reg;
    logic                    sel_timeout;

    assign sel_timeout = (paddr[APB_ADDR_BITS-1] == REG_IDX_IDLE_TIMEOUT);
    assign pready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= '0;
        end
        else if (psel && penable && pwrite && sel_timeout)
        begin
            idle_timeout_reg <= pwdata[TIMEOUT_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_timeout)
        begin
            prdata = APB_DATA_BITS'(idle_timeout_reg);
        end
    end

    assign idle_timeout = idle_timeout_reg;

endmodule

>>> rtl/lpwc_core.sv
// lpwc_core: mode and wake state machines, idle countdown and result register
// depends on lpwc_pkg and the lpwc channel interfaces
module lpwc_core
    import lpwc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [TIMEOUT_BITS-1:0] idle_timeout,
    lpwc_evt_if.sink                evt,
    lpwc_res_if.source              res
);

    localparam int WIDE_BITS = (COUNT_BITS > TIMEOUT_BITS) ? COUNT_BITS : TIMEOUT_BITS;

    logic [1:0]            mode_reg, mode_next;
    logic [1:0]            wake_reg, wake_next;
    logic                  tx_fin_reg, tx_fin_next;
    logic                  cd_active_reg, cd_active_next;
    logic [COUNT_BITS-1:0] cd_value_reg, cd_value_next;

    logic                  res_valid_reg;
    logic [1:0]            req_reg, req_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [1:0]            status_reg, status_next;

    logic                  accept;
    logic                  start_cd;
    logic [COUNT_BITS-1:0] cd_dec;
    logic [WIDE_BITS-1:0]  timeout_wide;
    logic [WIDE_BITS-1:0]  cnt_max_wide;
    logic [COUNT_BITS-1:0] load_value;

    assign evt.ready = !res_valid_reg || res.ready;
    assign accept    = evt.valid && evt.ready;

    // saturating load of the timeout into the counter
    assign timeout_wide = WIDE_BITS'(idle_timeout);
    assign cnt_max_wide = WIDE_BITS'({COUNT_BITS{1'b1}});
    assign load_value   = (timeout_wide > cnt_max_wide) ? {COUNT_BITS{1'b1}}
                                                        : timeout_wide[COUNT_BITS-1:0];
    assign cd_dec       = cd_value_reg - COUNT_BITS'(1);

    always_comb
    begin
        mode_next      = mode_reg;
        wake_next      = wake_reg;
        tx_fin_next    = tx_fin_reg;
        cd_active_next = cd_active_reg;
        cd_value_next  = cd_value_reg;
        req_next       = REQ_NONE;
        cmd_next       = CMD_NONE;
        status_next    = STAT_OK;
        start_cd       = 1'b0;

        case (evt.opcode)
            OP_DISABLE, OP_ENABLE:
            begin
                if (mode_reg == MODE_ENABLING || mode_reg == MODE_DISABLING)
                begin
                    status_next = STAT_BUSY;
                end
                else if ((mode_reg == MODE_ENABLED && evt.opcode == OP_ENABLE) ||
                         (mode_reg == MODE_DISABLED && evt.opcode == OP_DISABLE))
                begin
                    status_next = STAT_ALREADY;
                end
                else if (evt.opcode == OP_ENABLE)
                begin
                    mode_next = MODE_ENABLING;
                    req_next  = REQ_ENABLE;
                end
                else
                begin
                    mode_next = MODE_DISABLING;
                    req_next  = REQ_DISABLE;
                end
            end
            OP_WAKE_ASSERT:
            begin
                if (mode_reg != MODE_DISABLED)
                begin
                    cd_active_next = 1'b0;
                    cmd_next       = CMD_ASSERT;
                    wake_next      = WAKE_ASSERTED;
                end
                tx_fin_next = 1'b0;
            end
            OP_ALLOW_SLEEP:
            begin
                if (mode_reg == MODE_ENABLED && wake_reg == WAKE_ASSERTED)
                begin
                    if (tx_fin_reg)
                    begin
                        wake_next = WAKE_WAIT_IDLE;
                        start_cd  = 1'b1;
                    end
                    else
                    begin
                        wake_next = WAKE_WAIT_TX;
                    end
                end
            end
            OP_TX_DONE:
            begin
                tx_fin_next = 1'b1;
                if (wake_reg == WAKE_WAIT_TX || wake_reg == WAKE_ASSERTED)
                begin
                    wake_next = WAKE_WAIT_IDLE;
                    start_cd  = 1'b1;
                end
            end
            OP_MODE_DONE:
            begin
                if (mode_reg == MODE_ENABLING)
                begin
                    mode_next = evt.success ? MODE_ENABLED : MODE_DISABLED;
                end
                else if (mode_reg == MODE_DISABLING)
                begin
                    mode_next = evt.success ? MODE_DISABLED : MODE_ENABLED;
                end
                else
                begin
                    status_next = STAT_BUSY;
                end
                if (mode_next == MODE_DISABLED)
                begin
                    mode_next      = MODE_DISABLED;
                    wake_next      = WAKE_DEASSERTED;
                    tx_fin_next    = 1'b1;
                    cd_active_next = 1'b0;
                    cd_value_next  = '0;
                end
            end
            OP_TICK:
            begin
                if (cd_active_reg)
                begin
                    cd_value_next = cd_dec;
                    if (cd_dec == '0)
                    begin
                        cd_active_next = 1'b0;
                        if (mode_reg == MODE_ENABLED && wake_reg == WAKE_WAIT_IDLE &&
                            tx_fin_reg)
                        begin
                            cmd_next  = CMD_DEASSERT;
                            wake_next = WAKE_DEASSERTED;
                        end
                    end
                end
            end
            default:
            begin
                status_next = STAT_UNKNOWN;
            end
        endcase

        // countdown start, with immediate deassert on a zero timeout
        if (start_cd && mode_reg == MODE_ENABLED)
        begin
            if (idle_timeout == '0)
            begin
                if (tx_fin_next)
                begin
                    cmd_next  = CMD_DEASSERT;
                    wake_next = WAKE_DEASSERTED;
                end
            end
            else
            begin
                cd_value_next  = load_value;
                cd_active_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DISABLED;
            wake_reg      <= WAKE_DEASSERTED;
            tx_fin_reg    <= 1'b1;
            cd_active_reg <= 1'b0;
            cd_value_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                wake_reg      <= wake_next;
                tx_fin_reg    <= tx_fin_next;
                cd_active_reg <= cd_active_next;
                cd_value_reg  <= cd_value_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.mode_request  = req_reg;
    assign res.wake_command  = cmd_reg;
    assign res.status        = status_reg;
    assign res.mode_now      = mode_reg;
    assign res.wake_now      = wake_reg;
    assign res.timer_running = cd_active_reg;

endmodule
